// ----- rtl/mtsw_pkg.sv -----
// Shared types, codes and constants for the task stall watchdog.
`default_nettype none
package mtsw_pkg;

    // Default number of supervised task slots
    localparam int TASK_SLOTS_DEF = 8;

    // Field widths
    localparam int OP_W     = 3;
    localparam int ID_W     = 4;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int MISS_W   = 8;
    localparam int SEC_W    = 23;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // Millisecond to second conversion
    localparam int MS_PER_S = 1000;
    localparam int FRAC_W   = 10;

    // Configuration reset values
    localparam logic [TIME_W-1:0] CHECK_INTERVAL_RST = TIME_W'(1000);
    localparam logic [MISS_W-1:0] MISS_THRESHOLD_RST = MISS_W'(3);
    localparam logic [MISS_W-1:0] MISS_MAX = '1;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_KICK       = 3'd1,
        OP_REGISTER   = 3'd2,
        OP_UNREGISTER = 3'd3,
        OP_CHECKIN    = 3'd4,
        OP_QUERY      = 3'd5,
        OP_START      = 3'd6
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PARAM = 2'd1,
        ST_INACTIVE = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECK_INTERVAL = 1'd0,
        CFG_MISS_THRESHOLD = 1'd1
    } t_cfg_idx;

endpackage
`default_nettype wire

// ----- rtl/multi_task_stall_watchdog.sv -----
// Top level of the multi-slot task stall watchdog with its slot table and sequencer.
//
// Usage: items enter on i_in_valid/o_in_ready carrying op, task id and period; one
// result per item leaves on o_out_valid/i_out_ready. Configuration writes go through
// i_cfg_valid/o_cfg_ready (ready whenever out of reset) with a register index and
// data; the user must make them only while the block is idle, which it does not enforce.
// Sequence: a plain op passes through S_EXEC to S_FIN; a kick goes through S_CHECK
// and, when a table scan runs, S_SCAN before S_FIN, which loads the result once the
// output register is free. The scan visits one slot per cycle through a single
// subtract-and-compare unit, which also decides whether the check interval has
// elapsed. One item is in work at a time: o_in_ready returns when the result is
// loaded, so a new item is not taken before the last one is through.
// The result sits in an output register: a new item is taken while it waits, and
// the sequencer holds its finished result until the receiver frees the register.
// Reset (synchronous, active low) clears the clock, all slot flags and counters,
// the statistics and the output valid, and restores the configuration defaults.
`default_nettype none
module multi_task_stall_watchdog
    import mtsw_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input item channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [OP_W-1:0]       i_op,
    input  wire logic [ID_W-1:0]       i_task_id,
    input  wire logic [TIME_W-1:0]     i_period_ms,
    // Result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic                       o_task_stalled,
    output logic                       o_any_stalled,
    output logic [MISS_W-1:0]          o_miss_cnt,
    output logic [TIME_W-1:0]          o_checkin_cnt,
    output logic [TIME_W-1:0]          o_stalls_detected,
    output logic [ID_W-1:0]            o_recent_stall_slot,
    output logic [SEC_W-1:0]           o_stall_time_s,
    output logic                       o_check_ran,
    output logic [TIME_W-1:0]          o_kick_count,
    // Configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state;

    // Latched item
    t_op               r_op;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_period;
    logic [IDX_W-1:0]  r_idx;
    t_status           r_status;
    logic              r_ran;

    // Global state
    logic [TIME_W-1:0] r_now;
    logic [FRAC_W-1:0] r_ms_frac;
    logic [SEC_W-1:0]  r_sec;
    logic [TIME_W-1:0] r_last_check;
    logic [TIME_W-1:0] r_stall_counter;
    logic [ID_W-1:0]   r_recent_slot;
    logic [SEC_W-1:0]  r_recent_sec;
    logic [TIME_W-1:0] r_kicks;
    logic [TIME_W-1:0] r_check_interval;
    logic [MISS_W-1:0] r_miss_threshold;

    // Slot table
    logic [TASK_SLOTS-1:0] r_active;
    logic [TASK_SLOTS-1:0] r_stalled;
    logic [TIME_W-1:0]     r_slot_period [TASK_SLOTS];
    logic [TIME_W-1:0]     r_slot_checkin [TASK_SLOTS];
    logic [MISS_W-1:0]     r_slot_misses [TASK_SLOTS];
    logic [TIME_W-1:0]     r_slot_checkins [TASK_SLOTS];

    // Result register
    logic                r_out_valid;
    t_status             r_o_status;
    logic                r_o_task_stalled;
    logic                r_o_any_stalled;
    logic [MISS_W-1:0]   r_o_miss_cnt;
    logic [TIME_W-1:0]   r_o_checkin_cnt;
    logic [TIME_W-1:0]   r_o_stalls_detected;
    logic [ID_W-1:0]     r_o_recent_stall_slot;
    logic [SEC_W-1:0]    r_o_stall_time_s;
    logic                r_o_check_ran;
    logic [TIME_W-1:0]   r_o_kick_count;

    // Shared elapsed-time unit: (now - base) compared against a limit
    logic [TIME_W-1:0] cmp_base;
    logic [TIME_W-1:0] cmp_limit;
    logic [TIME_W-1:0] cmp_diff;
    logic              cmp_ge;
    logic              cmp_gt;

    logic              id_valid;
    logic [MISS_W-1:0] miss_inc;
    logic              out_free;

    // Select operands for the shared unit by sequencer step
    always_comb begin
        if (r_state == S_SCAN) begin
            cmp_base  = r_slot_checkin[r_idx];
            cmp_limit = r_slot_period[r_idx];
        end else begin
            cmp_base  = r_last_check;
            cmp_limit = r_check_interval;
        end
        cmp_diff = r_now - cmp_base;
        cmp_ge   = (cmp_diff >= cmp_limit);
        cmp_gt   = (cmp_diff > cmp_limit);
    end

    assign id_valid = ({1'b0, r_id} < (ID_W + 1)'(TASK_SLOTS));
    assign miss_inc = (r_slot_misses[r_idx] == MISS_MAX) ? MISS_MAX
                                                         : r_slot_misses[r_idx] + 1'b1;
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer, slot table, statistics, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_now            <= '0;
            r_ms_frac        <= '0;
            r_sec            <= '0;
            r_last_check     <= '0;
            r_stall_counter  <= '0;
            r_recent_slot    <= '0;
            r_recent_sec     <= '0;
            r_kicks          <= '0;
            r_check_interval <= CHECK_INTERVAL_RST;
            r_miss_threshold <= MISS_THRESHOLD_RST;
            r_active         <= '0;
            r_stalled        <= '0;
            r_out_valid      <= 1'b0;
            r_ran            <= 1'b0;
            r_status         <= ST_OK;
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_slot_misses[k]   <= '0;
                r_slot_checkins[k] <= '0;
            end
        end else begin
            // Drop the result once it is taken, unless a new one is loaded now
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            // Write configuration registers
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_CHECK_INTERVAL: r_check_interval <= i_cfg_data;
                    CFG_MISS_THRESHOLD: r_miss_threshold <= i_cfg_data[MISS_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                // Latch an incoming item
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= t_op'(i_op);
                        r_id     <= i_task_id;
                        r_period <= i_period_ms;
                        r_idx    <= i_task_id[IDX_W-1:0];
                        r_status <= ST_OK;
                        r_ran    <= 1'b0;
                        r_state  <= (t_op'(i_op) == OP_KICK) ? S_CHECK : S_EXEC;
                    end
                end

                // Apply a single-slot or clock op
                S_EXEC: begin
                    r_state <= S_FIN;
                    unique case (r_op)
                        OP_TICK: begin
                            if (r_now == '1) begin
                                r_ms_frac <= '0;
                                r_sec     <= '0;
                            end else if (r_ms_frac == FRAC_W'(MS_PER_S - 1)) begin
                                r_ms_frac <= '0;
                                r_sec     <= r_sec + 1'b1;
                            end else begin
                                r_ms_frac <= r_ms_frac + 1'b1;
                            end
                            r_now <= r_now + 1'b1;
                        end
                        OP_REGISTER: begin
                            if (!id_valid || r_period == '0) begin
                                r_status <= ST_BAD_PARAM;
                            end else begin
                                r_slot_period[r_idx]   <= r_period;
                                r_slot_checkin[r_idx]  <= r_now;
                                r_slot_misses[r_idx]   <= '0;
                                r_slot_checkins[r_idx] <= '0;
                                r_active[r_idx]        <= 1'b1;
                                r_stalled[r_idx]       <= 1'b0;
                            end
                        end
                        OP_UNREGISTER: begin
                            if (!id_valid) begin
                                r_status <= ST_BAD_PARAM;
                            end else begin
                                r_active[r_idx] <= 1'b0;
                            end
                        end
                        OP_CHECKIN: begin
                            if (!id_valid) begin
                                r_status <= ST_BAD_PARAM;
                            end else if (!r_active[r_idx]) begin
                                r_status <= ST_INACTIVE;
                            end else begin
                                r_slot_checkin[r_idx]  <= r_now;
                                r_slot_misses[r_idx]   <= '0;
                                r_stalled[r_idx]       <= 1'b0;
                                r_slot_checkins[r_idx] <= r_slot_checkins[r_idx] + 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            if (!id_valid) begin
                                r_status <= ST_BAD_PARAM;
                            end
                        end
                        OP_START: begin
                            r_last_check <= r_now;
                        end
                        default: begin
                            r_status <= ST_BAD_PARAM;
                        end
                    endcase
                end

                // Count the kick and decide whether a scan is due
                S_CHECK: begin
                    r_kicks <= r_kicks + 1'b1;
                    if (cmp_ge) begin
                        r_last_check <= r_now;
                        r_ran        <= 1'b1;
                        r_idx        <= '0;
                        r_state      <= S_SCAN;
                    end else begin
                        r_state <= S_FIN;
                    end
                end

                // Visit one slot per cycle
                S_SCAN: begin
                    if (r_active[r_idx]) begin
                        if (cmp_gt) begin
                            r_slot_misses[r_idx] <= miss_inc;
                            if (miss_inc >= r_miss_threshold && !r_stalled[r_idx]) begin
                                r_stalled[r_idx] <= 1'b1;
                                r_stall_counter  <= r_stall_counter + 1'b1;
                                r_recent_slot    <= ID_W'(r_idx);
                                r_recent_sec     <= r_sec;
                            end
                        end else begin
                            r_slot_misses[r_idx] <= '0;
                            r_stalled[r_idx]     <= 1'b0;
                        end
                    end
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= r_id[IDX_W-1:0];
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end

                // Load the result once the output register is free
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid           <= 1'b1;
                        r_o_status            <= r_status;
                        r_o_task_stalled      <= id_valid && r_stalled[r_idx];
                        r_o_any_stalled       <= |(r_active & r_stalled);
                        r_o_miss_cnt          <= id_valid ? r_slot_misses[r_idx] : '0;
                        r_o_checkin_cnt       <= id_valid ? r_slot_checkins[r_idx] : '0;
                        r_o_stalls_detected   <= r_stall_counter;
                        r_o_recent_stall_slot <= r_recent_slot;
                        r_o_stall_time_s      <= r_recent_sec;
                        r_o_check_ran         <= r_ran;
                        r_o_kick_count        <= r_kicks;
                        r_state               <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready          = (r_state == S_IDLE) && i_rst_n;
    assign o_cfg_ready         = i_rst_n;
    assign o_out_valid         = r_out_valid;
    assign o_status            = r_o_status;
    assign o_task_stalled      = r_o_task_stalled;
    assign o_any_stalled       = r_o_any_stalled;
    assign o_miss_cnt          = r_o_miss_cnt;
    assign o_checkin_cnt       = r_o_checkin_cnt;
    assign o_stalls_detected   = r_o_stalls_detected;
    assign o_recent_stall_slot = r_o_recent_stall_slot;
    assign o_stall_time_s      = r_o_stall_time_s;
    assign o_check_ran         = r_o_check_ran;
    assign o_kick_count        = r_o_kick_count;

endmodule
`default_nettype wire

// ----- dv/multi_task_stall_watchdog_tb.sv -----
// Self-checking testbench for the multi-slot task stall watchdog.
`timescale 1ns / 1ps
module multi_task_stall_watchdog_tb;
    import mtsw_pkg::*;

    localparam int SLOTS = TASK_SLOTS_DEF;

    // One report as the block should return it
    typedef struct {
        t_status            status;
        logic               task_stalled;
        logic               any_stalled;
        logic [MISS_W-1:0]  miss_cnt;
        logic [TIME_W-1:0]  checkin_cnt;
        logic [TIME_W-1:0]  stalls_detected;
        logic [ID_W-1:0]    recent_stall_slot;
        logic [SEC_W-1:0]   stall_time_s;
        logic               check_ran;
        logic [TIME_W-1:0]  kick_count;
    } t_wd_report;

    // One row of the directed stimulus, with an optional typed-in status
    typedef struct {
        t_op                op;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  period;
        bit                 typed;
        t_status            status;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_op;
    logic [ID_W-1:0]       i_task_id;
    logic [TIME_W-1:0]     i_period_ms;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_task_stalled;
    logic                  o_any_stalled;
    logic [MISS_W-1:0]     o_miss_cnt;
    logic [TIME_W-1:0]     o_checkin_cnt;
    logic [TIME_W-1:0]     o_stalls_detected;
    logic [ID_W-1:0]       o_recent_stall_slot;
    logic [SEC_W-1:0]      o_stall_time_s;
    logic                  o_check_ran;
    logic [TIME_W-1:0]     o_kick_count;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    multi_task_stall_watchdog #(.TASK_SLOTS(SLOTS)) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_op                (i_op),
        .i_task_id           (i_task_id),
        .i_period_ms         (i_period_ms),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_task_stalled      (o_task_stalled),
        .o_any_stalled       (o_any_stalled),
        .o_miss_cnt          (o_miss_cnt),
        .o_checkin_cnt       (o_checkin_cnt),
        .o_stalls_detected   (o_stalls_detected),
        .o_recent_stall_slot (o_recent_stall_slot),
        .o_stall_time_s      (o_stall_time_s),
        .o_check_ran         (o_check_ran),
        .o_kick_count        (o_kick_count),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Watchdog state mirrored by the predictor
    logic [TIME_W-1:0] clk_ms;
    logic [TIME_W-1:0] scan_mark;
    logic              slot_live    [SLOTS];
    logic              slot_stalled [SLOTS];
    logic [TIME_W-1:0] slot_period  [SLOTS];
    logic [TIME_W-1:0] seen_at      [SLOTS];
    logic [MISS_W-1:0] slot_misses  [SLOTS];
    logic [TIME_W-1:0] slot_checkins[SLOTS];
    logic [TIME_W-1:0] stall_total;
    logic [ID_W-1:0]   stall_slot;
    logic [SEC_W-1:0]  stall_sec;
    logic [TIME_W-1:0] kick_total;
    logic [TIME_W-1:0] interval_cfg;
    logic [MISS_W-1:0] threshold_cfg;

    t_wd_report watchdog_reports[$];
    int  error_total;
    int  items_sent;
    int  scans_run;
    int  settings_used;
    bit  idle_on;
    bit  result_hold_req;

    // Directed stimulus: errors, extremes, stall, unregister and check-in cases
    t_stim_row directed_rows [25] = '{
        '{OP_QUERY,      4'd0,  32'd0,          1'b1, ST_OK},
        '{OP_QUERY,      4'd15, 32'd0,          1'b1, ST_BAD_PARAM},
        '{OP_REGISTER,   4'd8,  32'd5,          1'b1, ST_BAD_PARAM},
        '{OP_REGISTER,   4'd0,  32'd0,          1'b1, ST_BAD_PARAM},
        '{OP_CHECKIN,    4'd1,  32'd0,          1'b1, ST_INACTIVE},
        '{OP_UNREGISTER, 4'd15, 32'hFFFF_FFFF,  1'b1, ST_BAD_PARAM},
        '{OP_REGISTER,   4'd0,  32'hFFFF_FFFF,  1'b1, ST_OK},
        '{OP_REGISTER,   4'd7,  32'd1,          1'b1, ST_OK},
        '{OP_REGISTER,   4'd3,  32'd2,          1'b1, ST_OK},
        '{OP_START,      4'd9,  32'hFFFF_FFFF,  1'b1, ST_OK},
        '{OP_TICK,       4'd15, 32'hFFFF_FFFF,  1'b1, ST_OK},
        '{OP_TICK,       4'd0,  32'd0,          1'b0, ST_OK},
        '{OP_KICK,       4'd7,  32'd0,          1'b0, ST_OK},
        '{OP_TICK,       4'd0,  32'd0,          1'b0, ST_OK},
        '{OP_KICK,       4'd3,  32'd0,          1'b0, ST_OK},
        '{OP_QUERY,      4'd7,  32'd0,          1'b0, ST_OK},
        '{OP_CHECKIN,    4'd7,  32'd0,          1'b0, ST_OK},
        '{OP_UNREGISTER, 4'd3,  32'd0,          1'b0, ST_OK},
        '{OP_QUERY,      4'd3,  32'd0,          1'b0, ST_OK},
        '{OP_CHECKIN,    4'd3,  32'd0,          1'b1, ST_INACTIVE},
        '{OP_KICK,       4'd0,  32'd0,          1'b0, ST_OK},
        '{OP_UNREGISTER, 4'd8,  32'd0,          1'b1, ST_BAD_PARAM},
        '{OP_QUERY,      4'd8,  32'd0,          1'b1, ST_BAD_PARAM},
        '{OP_REGISTER,   4'd5,  32'h8000_0000,  1'b0, ST_OK},
        '{OP_CHECKIN,    4'd0,  32'd0,          1'b0, ST_OK}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clear the mirrored state to its after-reset values
    function automatic void reset_watchdog_state();
        clk_ms = '0;
        scan_mark = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_stalled[i] = 1'b0;
            slot_period[i] = '0;
            seen_at[i] = '0;
            slot_misses[i] = '0;
            slot_checkins[i] = '0;
        end
        stall_total = '0;
        stall_slot = '0;
        stall_sec = '0;
        kick_total = '0;
        interval_cfg = CHECK_INTERVAL_RST;
        threshold_cfg = MISS_THRESHOLD_RST;
    endfunction

    // Visit every live slot: count misses, mark stalls, clear slots within period
    function automatic void scan_task_table();
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
                if (clk_ms - seen_at[i] > slot_period[i]) begin
                    if (slot_misses[i] != MISS_MAX)
                        slot_misses[i] = slot_misses[i] + 1'b1;
                    if (slot_misses[i] >= threshold_cfg && !slot_stalled[i]) begin
                        slot_stalled[i] = 1'b1;
                        stall_total = stall_total + 1;
                        stall_slot = ID_W'(i);
                        stall_sec = SEC_W'(clk_ms / TIME_W'(MS_PER_S));
                    end
                end else begin
                    slot_misses[i] = '0;
                    slot_stalled[i] = 1'b0;
                end
            end
        end
    endfunction

    // Apply one op to the mirrored state and return the report it produces
    function automatic t_wd_report apply_watchdog_op(input t_op op,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [TIME_W-1:0] period);
        t_wd_report r;
        bit in_range;
        int slot;
        in_range = (int'(id) < SLOTS);
        slot = int'(id);
        r.status = ST_OK;
        r.check_ran = 1'b0;
        case (op)
            OP_TICK: clk_ms = clk_ms + 1;
            OP_KICK: begin
                kick_total = kick_total + 1;
                if (clk_ms - scan_mark >= interval_cfg) begin
                    scan_task_table();
                    scan_mark = clk_ms;
                    r.check_ran = 1'b1;
                    scans_run++;
                end
            end
            OP_REGISTER: begin
                if (!in_range || period == '0) begin
                    r.status = ST_BAD_PARAM;
                end else begin
                    slot_period[slot] = period;
                    seen_at[slot] = clk_ms;
                    slot_misses[slot] = '0;
                    slot_checkins[slot] = '0;
                    slot_live[slot] = 1'b1;
                    slot_stalled[slot] = 1'b0;
                end
            end
            OP_UNREGISTER: begin
                if (!in_range)
                    r.status = ST_BAD_PARAM;
                else
                    slot_live[slot] = 1'b0;
            end
            OP_CHECKIN: begin
                if (!in_range) begin
                    r.status = ST_BAD_PARAM;
                end else if (!slot_live[slot]) begin
                    r.status = ST_INACTIVE;
                end else begin
                    seen_at[slot] = clk_ms;
                    slot_misses[slot] = '0;
                    slot_stalled[slot] = 1'b0;
                    slot_checkins[slot] = slot_checkins[slot] + 1;
                end
            end
            OP_QUERY: begin
                if (!in_range)
                    r.status = ST_BAD_PARAM;
            end
            OP_START: scan_mark = clk_ms;
            default: r.status = ST_BAD_PARAM;
        endcase
        r.task_stalled = 1'b0;
        r.miss_cnt = '0;
        r.checkin_cnt = '0;
        if (in_range) begin
            r.task_stalled = slot_stalled[slot];
            r.miss_cnt = slot_misses[slot];
            r.checkin_cnt = slot_checkins[slot];
        end
        r.any_stalled = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_stalled[i])
                r.any_stalled = 1'b1;
        r.stalls_detected = stall_total;
        r.recent_stall_slot = stall_slot;
        r.stall_time_s = stall_sec;
        r.kick_count = kick_total;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_total++;
        end
    endtask

    // Compare one report transfer with the oldest expectation
    task automatic check_report();
        t_wd_report want;
        if (watchdog_reports.size() == 0) begin
            $error("report transfer with no expectation pending");
            error_total++;
        end else begin
            want = watchdog_reports.pop_front();
            check_field("status", 64'(want.status), 64'(o_status));
            check_field("task_stalled", 64'(want.task_stalled), 64'(o_task_stalled));
            check_field("any_stalled", 64'(want.any_stalled), 64'(o_any_stalled));
            check_field("miss_cnt", 64'(want.miss_cnt), 64'(o_miss_cnt));
            check_field("checkin_cnt", 64'(want.checkin_cnt), 64'(o_checkin_cnt));
            check_field("stalls_detected", 64'(want.stalls_detected),
                        64'(o_stalls_detected));
            check_field("recent_stall_slot", 64'(want.recent_stall_slot),
                        64'(o_recent_stall_slot));
            check_field("stall_time_s", 64'(want.stall_time_s), 64'(o_stall_time_s));
            check_field("check_ran", 64'(want.check_ran), 64'(o_check_ran));
            check_field("kick_count", 64'(want.kick_count), 64'(o_kick_count));
        end
    endtask

    // Report side: check transfers, drive ready with stall bursts and a long hold
    initial begin
        int burst_left;
        int hold_left;
        burst_left = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                check_report();
            if (result_hold_req) begin
                hold_left = 200;
                result_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(1, 10) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one op, optionally after an idle burst, and record its expected report
    task automatic send_item(input t_op op, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] period, input bit typed,
                             input t_status want_status);
        t_wd_report r;
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_task_id <= id;
        i_period_ms <= period;
        do @(posedge i_clk); while (!o_in_ready);
        r = apply_watchdog_op(op, id, period);
        if (typed)
            r.status = want_status;
        watchdog_reports.push_back(r);
        items_sent++;
    endtask

    // Drain the block, then write both registers back to back
    task automatic write_settings(input logic [TIME_W-1:0] interval,
                                  input logic [MISS_W-1:0] threshold);
        i_in_valid <= 1'b0;
        wait (watchdog_reports.size() == 0);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_CHECK_INTERVAL;
        i_cfg_data <= interval;
        do @(posedge i_clk); while (!o_cfg_ready);
        interval_cfg = interval;
        i_cfg_index <= CFG_MISS_THRESHOLD;
        i_cfg_data <= CFG_DATA_W'(threshold);
        do @(posedge i_clk); while (!o_cfg_ready);
        threshold_cfg = threshold;
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic t_op pick_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 30) return OP_TICK;
        if (w < 55) return OP_KICK;
        if (w < 65) return OP_REGISTER;
        if (w < 69) return OP_UNREGISTER;
        if (w < 87) return OP_CHECKIN;
        if (w < 97) return OP_QUERY;
        return OP_START;
    endfunction

    // Mostly in-range slot ids, some out of range
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 4) == 0)
            return ID_W'($urandom_range(SLOTS, 15));
        return ID_W'($urandom_range(0, SLOTS - 1));
    endfunction

    // Mostly short periods so that misses happen, some zero and some wide
    function automatic logic [TIME_W-1:0] pick_period();
        int w;
        w = $urandom_range(0, 9);
        if (w == 0) return '0;
        if (w < 3) return TIME_W'($urandom());
        return TIME_W'($urandom_range(1, 12));
    endfunction

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++)
            send_item(pick_op(), pick_id(), pick_period(), 1'b0, ST_OK);
    endtask

    // Main sequence
    initial begin
        error_total = 0;
        items_sent = 0;
        scans_run = 0;
        settings_used = 0;
        idle_on = 1'b1;
        result_hold_req = 1'b0;
        reset_watchdog_state();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_op <= OP_TICK;
        i_task_id <= '0;
        i_period_ms <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_CHECK_INTERVAL;
        i_cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table with the lowest interval and threshold
        write_settings(32'd1, 8'd1);
        foreach (directed_rows[n])
            send_item(directed_rows[n].op, directed_rows[n].id, directed_rows[n].period,
                      directed_rows[n].typed, directed_rows[n].status);
        send_random(300);

        // Mid settings, opened by a long receiver hold-off
        write_settings(32'd7, 8'd3);
        result_hold_req = 1'b1;
        send_random(300);

        // Highest threshold: scan every tick until the miss counts saturate
        write_settings(32'd1, 8'd255);
        for (int s = 0; s < SLOTS; s++)
            send_item(OP_REGISTER, ID_W'(s), TIME_W'($urandom_range(1, 3)), 1'b0, ST_OK);
        for (int k = 0; k < 280; k++) begin
            send_item(OP_TICK, pick_id(), pick_period(), 1'b0, ST_OK);
            send_item(OP_KICK, pick_id(), pick_period(), 1'b0, ST_OK);
            if ($urandom_range(0, 9) == 0)
                send_item(OP_QUERY, pick_id(), pick_period(), 1'b0, ST_OK);
        end

        // Widest interval: kicks never scan
        write_settings(32'hFFFF_FFFF, 8'd255);
        send_random(100);

        // Final stretch with no idling on either side
        write_settings(32'd3, 8'd2);
        idle_on = 1'b0;
        send_random(350);

        // Drain and let any stray report show up
        i_in_valid <= 1'b0;
        wait (watchdog_reports.size() == 0);
        repeat (SLOTS + 6) @(posedge i_clk);

        $display("Covered %0d ops over %0d register settings: %0d table scans, %0d stalls.",
                 items_sent, settings_used, scans_run, stall_total);
        if (error_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog on the run itself
    initial begin
        #5_000_000;
        $error("run did not finish in time");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
